// ----- hw/rtl/gwrs_pkg.sv -----
// Shared widths, register codes and constants for the geometric window statistics unit.
package gwrs_pkg;

   localparam int unsigned NUM_BINS_DEF = 32;

   localparam int TIME_W    = 32;
   localparam int VALUE_W   = 32;
   localparam int IDXO_W    = 5;
   localparam int BTIME_W   = 40;
   localparam int MEAN_W    = 48;
   localparam int VAR_W     = 64;
   localparam int CNT_W     = 32;
   localparam int CSR_W     = 32;
   localparam int CSR_IDX_W = 2;
   localparam int EDGE_W    = 49;

   localparam logic [EDGE_W-1:0]  EDGE_CAP = {1'b1, {(EDGE_W-1){1'b0}}};
   localparam logic [BTIME_W-1:0] TIME_MAX = '1;
   localparam logic [VAR_W-1:0]   VAR_MAX  = '1;
   localparam logic [CNT_W-1:0]   CNT_MAX  = '1;

   localparam logic [15:0] FIRST_WIDTH_RST = 16'd1;
   localparam logic [12:0] GROWTH_RST      = 13'd512;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_TIME  = 2'd0,
      CSR_FIRST_WIDTH = 2'd1,
      CSR_GROWTH      = 2'd2
   } csr_index_type;

endpackage

// ----- hw/rtl/gwrs_if.sv -----
// Request and response channel interfaces of the geometric window statistics unit.
interface gwrs_req_if;
   import gwrs_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      kind;
   logic [TIME_W-1:0]         sample_time;
   logic signed [VALUE_W-1:0] sample_value;
   modport source (output valid, kind, sample_time, sample_value, input ready);
   modport sink (input valid, kind, sample_time, sample_value, output ready);
endinterface

interface gwrs_rsp_if;
   import gwrs_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [IDXO_W-1:0]        bin_index;
   logic [BTIME_W-1:0]       bin_time;
   logic signed [MEAN_W-1:0] bin_mean;
   logic [VAR_W-1:0]         bin_variance;
   logic [CNT_W-1:0]         sample_count;
   logic                     single_sample;
   logic                     samples_dropped;
   logic                     last;
   modport source (output valid, bin_index, bin_time, bin_mean, bin_variance, sample_count,
                   single_sample, samples_dropped, last, input ready);
   modport sink (input valid, bin_index, bin_time, bin_mean, bin_variance, sample_count,
                 single_sample, samples_dropped, last, output ready);
endinterface

// ----- hw/rtl/geometric_window_running_stats_unit.sv -----
// Geometric window running statistics: bin search, Welford update and dump sequencer.
//
//   channel   direction  word
//   req_ch    in         kind, sample_time, sample_value
//   rsp_ch    out        bin_index, bin_time, bin_mean, bin_variance, sample_count, flags
//   csr_*     in         write enable, register index, write data
//
// Accumulate: an edge search over the windows, then a read step and a load step, the shared
// serial divider, the steps on the shared 32x32 multiplier and a write. Early samples are
// dropped without a search; late samples are dropped and flagged once the search passes the last window.
// Dump: a scan of every window, then per bin a step and a load, plus the divider when count >= 2,
// plus an emit step that waits for the output register to drain.
// Reset is synchronous; it clears the valid bit of every window, so no clearing pass runs.
// A stalled response holds the dump sequencer; req_ch is ready only when no word is in work.
module geometric_window_running_stats_unit #(
   parameter int unsigned NUM_BINS = gwrs_pkg::NUM_BINS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   gwrs_req_if.sink                          req_ch,
   gwrs_rsp_if.source                        rsp_ch,
   input  logic                              csr_wr_en,
   input  logic [gwrs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gwrs_pkg::CSR_W-1:0]        csr_wr_data
);
   import gwrs_pkg::*;

   localparam int IDX_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BINS - 1);
   localparam logic [5:0] DIV_LAST = 6'd63;

   localparam logic [3:0] MS_A0B0  = 4'd0;
   localparam logic [3:0] MS_A1B0  = 4'd1;
   localparam logic [3:0] MS_A0B1  = 4'd2;
   localparam logic [3:0] MS_A1B1  = 4'd3;
   localparam logic [3:0] MS_HIGH  = 4'd4;
   localparam logic [3:0] MS_SAT   = 4'd5;
   localparam logic [3:0] MS_X0M   = 4'd6;
   localparam logic [3:0] MS_X1M   = 4'd7;
   localparam logic [3:0] MS_TERM  = 4'd8;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SEARCH, ST_RD, ST_LOAD, ST_DIVM, ST_MUL, ST_WRITE,
      ST_DSCAN, ST_DSTEP, ST_DLOAD, ST_DDIV, ST_DEMIT
   } state_type;

   state_type state_ff;

   logic [TIME_W-1:0]  start_ff;
   logic [15:0]        fwidth_ff;
   logic [12:0]        growth_ff;
   logic               overflow_ff;

   logic [IDX_W-1:0]   k_ff, lastk_ff;
   logic               any_ff;
   logic [BTIME_W-1:0] dq_ff;
   logic [EDGE_W-1:0]  s_ff, w_ff;
   logic [VALUE_W-1:0] val_ff;

   logic [CNT_W-1:0]   cnt_mem  [NUM_BINS];
   logic [MEAN_W-1:0]  mean_mem [NUM_BINS];
   logic [VAR_W-1:0]   m2_mem   [NUM_BINS];
   logic [NUM_BINS-1:0] valid_ff;
   logic [CNT_W-1:0]   rd_cnt_ff;
   logic [MEAN_W-1:0]  rd_mean_ff;
   logic [VAR_W-1:0]   rd_m2_ff;
   logic               rd_valid_ff;

   logic [CNT_W-1:0]   n_ff;
   logic [MEAN_W-1:0]  mean_old_ff, mean_new_ff;
   logic [VAR_W-1:0]   m2_old_ff;
   logic               q_neg_ff;
   logic [EDGE_W-1:0]  uq_ff, ur_ff;

   logic [3:0]         step_ff;
   logic [63:0]        mp_ff, p0_ff, x_ff, term_ff;
   logic [66:0]        acc_ff;

   logic [31:0]        dv_rem_ff, dv_den_ff;
   logic [63:0]        dv_quo_ff;
   logic [5:0]         dv_cnt_ff;

   logic [BTIME_W-1:0] mid_ff;
   logic [IDXO_W-1:0]  st_idx_ff;
   logic [MEAN_W-1:0]  st_mean_ff;
   logic [VAR_W-1:0]   st_var_ff;
   logic [CNT_W-1:0]   st_cnt_ff;
   logic               st_single_ff, st_last_ff;

   logic               rsp_valid_ff;
   logic [IDXO_W-1:0]  rsp_idx_ff;
   logic [BTIME_W-1:0] rsp_time_ff;
   logic [MEAN_W-1:0]  rsp_mean_ff;
   logic [VAR_W-1:0]   rsp_var_ff;
   logic [CNT_W-1:0]   rsp_cnt_ff;
   logic               rsp_single_ff, rsp_drop_ff, rsp_last_ff;

   // combinational helpers
   logic               early;
   logic [TIME_W-1:0]  t_diff;
   logic [EDGE_W:0]    s_sum;
   logic [EDGE_W-1:0]  s_in, w_in;
   logic [61:0]        w_prod;
   logic [53:0]        w_shift;
   logic [EDGE_W:0]    mid_sum, mid_full;
   logic [BTIME_W-1:0] t0q, mid_in;
   logic [32:0]        dv_shift;
   logic               dv_ge;
   logic [31:0]        dv_rem_in;
   logic [63:0]        dv_quo_in;
   logic [CNT_W-1:0]   cnt_new;
   logic [MEAN_W-1:0]  mean_sel;
   logic [VAR_W-1:0]   m2_sel;
   logic [EDGE_W-1:0]  q_cmb, q_abs, r_cmb, r_signed;
   logic [EDGE_W-1:0]  mean_sum;
   logic [31:0]        mul_a, mul_b, m_cmb;
   logic [63:0]        mul_p, x_in, term_in, m2_new;
   logic [64:0]        high, m2_sum;

   always_comb begin
      early   = req_ch.sample_time < start_ff;
      t_diff  = req_ch.sample_time - start_ff;

      s_sum   = {1'b0, s_ff} + {1'b0, w_ff};
      s_in    = (s_sum > {1'b0, EDGE_CAP}) ? EDGE_CAP : s_sum[EDGE_W-1:0];
      w_prod  = {13'b0, w_ff} * {49'b0, growth_ff};
      w_shift = w_prod[61:8];
      w_in    = (w_shift > {5'b0, EDGE_CAP}) ? EDGE_CAP : w_shift[EDGE_W-1:0];

      t0q      = {start_ff, 8'b0};
      mid_sum  = {1'b0, s_ff} + {1'b0, s_in};
      mid_full = {10'b0, t0q} + {1'b0, mid_sum[EDGE_W:1]};
      if (k_ff == '0) begin
         mid_in = t0q;
      end else if (mid_full > {10'b0, TIME_MAX}) begin
         mid_in = TIME_MAX;
      end else begin
         mid_in = mid_full[BTIME_W-1:0];
      end

      dv_shift  = {dv_rem_ff, dv_quo_ff[63]};
      dv_ge     = dv_shift >= {1'b0, dv_den_ff};
      dv_rem_in = dv_ge ? 32'(dv_shift - {1'b0, dv_den_ff}) : dv_shift[31:0];
      dv_quo_in = {dv_quo_ff[62:0], dv_ge};

      mean_sel = rd_valid_ff ? rd_mean_ff : '0;
      m2_sel   = rd_valid_ff ? rd_m2_ff : '0;
      if (!rd_valid_ff) begin
         cnt_new = 32'd1;
      end else if (rd_cnt_ff == CNT_MAX) begin
         cnt_new = rd_cnt_ff;
      end else begin
         cnt_new = rd_cnt_ff + 32'd1;
      end
      q_cmb = {val_ff[31], val_ff, 16'b0} - {mean_sel[47], mean_sel};
      q_abs = q_cmb[EDGE_W-1] ? (~q_cmb + 49'd1) : q_cmb;

      r_cmb    = dv_quo_in[EDGE_W-1:0];
      r_signed = q_neg_ff ? (~r_cmb + 49'd1) : r_cmb;
      mean_sum = {mean_old_ff[47], mean_old_ff} + r_signed;

      m_cmb = n_ff - 32'd1;
      case (step_ff)
         MS_A0B0: begin mul_a = uq_ff[31:0];                mul_b = ur_ff[31:0]; end
         MS_A1B0: begin mul_a = {15'b0, uq_ff[48:32]};      mul_b = ur_ff[31:0]; end
         MS_A0B1: begin mul_a = uq_ff[31:0];                mul_b = {15'b0, ur_ff[48:32]}; end
         MS_A1B1: begin mul_a = {15'b0, uq_ff[48:32]};      mul_b = {15'b0, ur_ff[48:32]}; end
         MS_X0M:  begin mul_a = x_ff[31:0];                 mul_b = m_cmb; end
         MS_X1M:  begin mul_a = x_ff[63:32];                mul_b = m_cmb; end
         default: begin mul_a = '0;                         mul_b = '0; end
      endcase
      mul_p = mul_a * mul_b;

      x_in    = (|acc_ff[66:64]) ? VAR_MAX : acc_ff[63:0];
      high    = {1'b0, mp_ff} + {33'b0, p0_ff[63:32]};
      term_in = (|high[64:32]) ? VAR_MAX : {high[31:0], p0_ff[31:0]};
      m2_sum  = {1'b0, m2_old_ff} + {1'b0, term_ff};
      m2_new  = m2_sum[64] ? VAR_MAX : m2_sum[63:0];
   end

   // window store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (state_ff == ST_WRITE) begin
         cnt_mem[k_ff]  <= n_ff;
         mean_mem[k_ff] <= mean_new_ff;
         m2_mem[k_ff]   <= m2_new;
      end
      rd_cnt_ff  <= cnt_mem[k_ff];
      rd_mean_ff <= mean_mem[k_ff];
      rd_m2_ff   <= m2_mem[k_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= '0;
         fwidth_ff    <= FIRST_WIDTH_RST;
         growth_ff    <= GROWTH_RST;
         overflow_ff  <= 1'b0;
         valid_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= valid_ff[k_ff];
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_START_TIME:  start_ff  <= csr_wr_data;
               CSR_FIRST_WIDTH: fwidth_ff <= csr_wr_data[15:0];
               CSR_GROWTH:      growth_ff <= csr_wr_data[12:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_ch.valid) begin
                  if (!req_ch.kind) begin
                     val_ff <= req_ch.sample_value;
                     dq_ff  <= {t_diff, 8'b0};
                     if (!early) begin
                        if (t_diff == '0) begin
                           k_ff     <= '0;
                           state_ff <= ST_RD;
                        end else begin
                           k_ff     <= IDX_W'(1);
                           s_ff     <= '0;
                           w_ff     <= {25'b0, fwidth_ff, 8'b0};
                           state_ff <= ST_SEARCH;
                        end
                     end
                  end else begin
                     k_ff     <= '0;
                     lastk_ff <= '0;
                     any_ff   <= 1'b0;
                     state_ff <= ST_DSCAN;
                  end
               end
            end
            ST_SEARCH: begin
               if ({9'b0, dq_ff} < s_in) begin
                  state_ff <= ST_RD;
               end else if (k_ff == LAST_IDX) begin
                  // beyond the last window: drop and flag
                  overflow_ff <= 1'b1;
                  state_ff    <= ST_IDLE;
               end else begin
                  s_ff <= s_in;
                  w_ff <= w_in;
                  k_ff <= k_ff + IDX_W'(1);
               end
            end
            ST_RD: state_ff <= ST_LOAD;
            ST_LOAD: begin
               n_ff        <= cnt_new;
               mean_old_ff <= mean_sel;
               m2_old_ff   <= m2_sel;
               q_neg_ff    <= q_cmb[EDGE_W-1];
               uq_ff       <= q_abs;
               dv_quo_ff   <= {15'b0, q_abs};
               dv_rem_ff   <= '0;
               dv_den_ff   <= cnt_new;
               dv_cnt_ff   <= '0;
               state_ff    <= ST_DIVM;
            end
            ST_DIVM: begin
               dv_rem_ff <= dv_rem_in;
               dv_quo_ff <= dv_quo_in;
               dv_cnt_ff <= dv_cnt_ff + 6'd1;
               if (dv_cnt_ff == DIV_LAST) begin
                  ur_ff       <= r_cmb;
                  mean_new_ff <= mean_sum[MEAN_W-1:0];
                  step_ff     <= MS_A0B0;
                  state_ff    <= ST_MUL;
               end
            end
            ST_MUL: begin
               step_ff <= step_ff + 4'd1;
               mp_ff   <= mul_p;
               case (step_ff)
                  MS_A1B0: acc_ff <= {35'b0, mp_ff[63:32]};
                  MS_A0B1, MS_A1B1: acc_ff <= acc_ff + {3'b0, mp_ff};
                  MS_HIGH: acc_ff <= acc_ff + {1'b0, mp_ff[33:0], 32'b0};
                  MS_SAT:  x_ff   <= x_in;
                  MS_X1M:  p0_ff  <= mp_ff;
                  MS_TERM: begin
                     term_ff  <= term_in;
                     state_ff <= ST_WRITE;
                  end
                  default: ;
               endcase
            end
            ST_WRITE: begin
               valid_ff[k_ff] <= 1'b1;
               state_ff       <= ST_IDLE;
            end
            ST_DSCAN: begin
               if (valid_ff[k_ff]) begin
                  any_ff   <= 1'b1;
                  lastk_ff <= k_ff;
               end
               if (k_ff == LAST_IDX) begin
                  if (!any_ff && !valid_ff[k_ff]) begin
                     // no window holds a sample: one empty closing word
                     st_idx_ff    <= '0;
                     mid_ff       <= '0;
                     st_mean_ff   <= '0;
                     st_var_ff    <= '0;
                     st_cnt_ff    <= '0;
                     st_single_ff <= 1'b0;
                     st_last_ff   <= 1'b1;
                     state_ff     <= ST_DEMIT;
                  end else begin
                     k_ff     <= '0;
                     s_ff     <= '0;
                     w_ff     <= {25'b0, fwidth_ff, 8'b0};
                     state_ff <= ST_DSTEP;
                  end
               end else begin
                  k_ff <= k_ff + IDX_W'(1);
               end
            end
            ST_DSTEP: begin
               mid_ff <= mid_in;
               if (k_ff != '0) begin
                  s_ff <= s_in;
                  w_ff <= w_in;
               end
               state_ff <= ST_DLOAD;
            end
            ST_DLOAD: begin
               if (rd_valid_ff) begin
                  st_idx_ff    <= IDXO_W'(k_ff);
                  st_mean_ff   <= rd_mean_ff;
                  st_cnt_ff    <= rd_cnt_ff;
                  st_single_ff <= rd_cnt_ff == 32'd1;
                  st_last_ff   <= k_ff == lastk_ff;
                  st_var_ff    <= '0;
                  if (rd_cnt_ff > 32'd1) begin
                     dv_quo_ff <= rd_m2_ff;
                     dv_rem_ff <= '0;
                     dv_den_ff <= rd_cnt_ff - 32'd1;
                     dv_cnt_ff <= '0;
                     state_ff  <= ST_DDIV;
                  end else begin
                     state_ff <= ST_DEMIT;
                  end
               end else begin
                  k_ff     <= k_ff + IDX_W'(1);
                  state_ff <= ST_DSTEP;
               end
            end
            ST_DDIV: begin
               dv_rem_ff <= dv_rem_in;
               dv_quo_ff <= dv_quo_in;
               dv_cnt_ff <= dv_cnt_ff + 6'd1;
               if (dv_cnt_ff == DIV_LAST) begin
                  st_var_ff <= dv_quo_in;
                  state_ff  <= ST_DEMIT;
               end
            end
            ST_DEMIT: begin
               // hold until the output register is free
               if (!rsp_valid_ff) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_idx_ff    <= st_idx_ff;
                  rsp_time_ff   <= mid_ff;
                  rsp_mean_ff   <= st_mean_ff;
                  rsp_var_ff    <= st_var_ff;
                  rsp_cnt_ff    <= st_cnt_ff;
                  rsp_single_ff <= st_single_ff;
                  rsp_drop_ff   <= overflow_ff;
                  rsp_last_ff   <= st_last_ff;
                  if (st_last_ff) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     k_ff     <= k_ff + IDX_W'(1);
                     state_ff <= ST_DSTEP;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ch.ready           = state_ff == ST_IDLE;
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.bin_index       = rsp_idx_ff;
   assign rsp_ch.bin_time        = rsp_time_ff;
   assign rsp_ch.bin_mean        = rsp_mean_ff;
   assign rsp_ch.bin_variance    = rsp_var_ff;
   assign rsp_ch.sample_count    = rsp_cnt_ff;
   assign rsp_ch.single_sample   = rsp_single_ff;
   assign rsp_ch.samples_dropped = rsp_drop_ff;
   assign rsp_ch.last            = rsp_last_ff;

   a_rsp_from_dump: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DEMIT))
      else $error("response word raised outside the dump emit step");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVM || state_ff == ST_DDIV) |-> dv_den_ff != '0)
      else $error("serial divider running with a zero divisor");

   a_overflow_sticky: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |=> overflow_ff)
      else $error("dropped-sample flag cleared without reset");

   a_last_ends_dump: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DEMIT && !rsp_valid_ff && st_last_ff) |=> state_ff == ST_IDLE)
      else $error("dump did not end after its last word");

endmodule
